@@ sv/rbd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGBA box downscaler package
// Shared widths, register indexes and the accumulator entry type.
// ----------------------------------------------------------------------------
package rbd_pkg;

    localparam int CFG_W     = 11;
    localparam int CFG_MAX   = (1 << CFG_W) - 1;
    localparam int FACT_W    = CFG_W + 1;
    localparam int PIX_W     = 8;
    localparam int CNT_W     = 2 * CFG_W;
    localparam int SUM_W     = PIX_W + CNT_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OUT_W  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OUT_H  = 2'd3;

    localparam logic [CFG_W-1:0] MAX_OUT_W_RESET = 11'd160;
    localparam logic [CFG_W-1:0] MAX_OUT_H_RESET = 11'd120;

    localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } rgb_sum_t;

endpackage

@@ sv/rbd_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGBA box downscaler divider
// Restoring divider, one quotient bit per cycle; quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module rbd_div #(
    parameter int DW = 8,
    parameter int VW = 8,
    parameter int QW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [QW-1:0] quotient
);

    localparam int SW = VW + QW;
    localparam int MW = (DW > SW) ? DW : SW;
    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0] rem_reg;
    logic [SW-1:0] den_reg;
    logic [QW-1:0] quo_reg;
    logic [CW-1:0] step_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [MW-1:0] rem_ext;
    logic [MW-1:0] den_ext;
    logic [MW-1:0] diff;
    logic          ge;

    assign rem_ext = MW'(rem_reg);
    assign den_ext = MW'(den_reg);
    assign ge      = rem_ext >= den_ext;
    assign diff    = rem_ext - den_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= !start && busy_reg && (step_reg == CW'(1));
            if (start) begin
                rem_reg  <= dividend;
                den_reg  <= SW'(divisor) << (QW - 1);
                quo_reg  <= '0;
                step_reg <= CW'(QW);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (ge) begin
                    rem_reg <= DW'(diff);
                end
                quo_reg  <= (quo_reg << 1) | QW'(ge);
                den_reg  <= den_reg >> 1;
                step_reg <= step_reg - CW'(1);
                if (step_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ sv/rbd_sum_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGBA box downscaler sum memory
// One row of per-column box sums, one write and one registered read port.
// ----------------------------------------------------------------------------
module rbd_sum_mem
    import rbd_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  rgb_sum_t      wr_data,
    input  logic [AW-1:0] rd_addr,
    output rgb_sum_t      rd_data
);

    rgb_sum_t mem [DEPTH];
    rgb_sum_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/rgba_box_downscaler_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGBA box downscaler core
// Box-filter downscale of a raster RGB stream by integer factors.
//
// Source pixels enter on the s_ channel in raster order, one transfer per
// pixel. Output pixels leave on the m_ channel in raster order with alpha
// fixed to opaque, the frame's output size, and a flag on the last one.
// The first pixel of a frame latches the size registers and runs a setup of
// four 11-step divisions and one multiply. After that each pixel is first
// accepted and then does one read-modify-write of the column sum memory.
// A pixel that closes a box then runs the 8-step mean divider and the load
// of the output register. The output register holds a finished pixel while
// the next source pixels are taken; a stalled receiver stops intake only
// when a second result is ready before the first leaves.
// Reset returns the block to the start of a frame with default registers.
// Zero width or height drops the pixel and produces no output.
// ----------------------------------------------------------------------------
module rgba_box_downscaler_core
    import rbd_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PIX_W-1:0]     s_red_in,
    input  logic [PIX_W-1:0]     s_green_in,
    input  logic [PIX_W-1:0]     s_blue_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PIX_W-1:0]     m_red_out,
    output logic [PIX_W-1:0]     m_green_out,
    output logic [PIX_W-1:0]     m_blue_out,
    output logic [PIX_W-1:0]     m_alpha_out,
    output logic                 m_last_of_frame,
    output logic [CFG_W-1:0]     m_output_width,
    output logic [CFG_W-1:0]     m_output_height
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [CFG_W-1:0] W_CAP = CFG_W'((MAX_WIDTH > CFG_MAX) ? CFG_MAX : MAX_WIDTH);
    localparam logic [CFG_W-1:0] H_CAP = CFG_W'((MAX_HEIGHT > CFG_MAX) ? CFG_MAX : MAX_HEIGHT);

    typedef enum logic [3:0] {
        S_IDLE, S_HF, S_VF, S_OW, S_OH, S_CNT, S_MOD, S_DIV, S_OUT
    } state_t;

    state_t             state_reg;
    logic [CFG_W-1:0]   src_w_reg, src_h_reg, max_ow_reg, max_oh_reg;
    logic [CFG_W-1:0]   fw_reg, fh_reg, ow_reg, oh_reg;
    logic [FACT_W-1:0]  hf_reg, vf_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CFG_W-1:0]   col_reg, row_reg, cx_reg, cy_reg, ox_reg, oy_reg;
    logic [PIX_W-1:0]   pix_red_reg, pix_green_reg, pix_blue_reg;
    logic               last_pend_reg;
    logic               sz_start_reg;
    logic               m_valid_reg;
    logic [PIX_W-1:0]   red_out_reg, green_out_reg, blue_out_reg;
    logic               last_out_reg;
    logic [CFG_W-1:0]   ow_out_reg, oh_out_reg;

    logic               accept, frame_start;
    logic [CFG_W-1:0]   fw_cap, fh_cap;
    logic [CFG_W-1:0]   sz_dividend;
    logic [FACT_W-1:0]  sz_divisor;
    logic [CFG_W-1:0]   sz_q;
    logic               sz_done;
    logic               sz_start_next;
    logic [CFG_W-1:0]   sz_size;
    logic [CFG_W-1:0]   bw, bh;
    logic               inbox, first, emit_x, emit_y, last_now;
    logic               col_end, row_end, cx_end, cy_end;
    logic               wr_en, mean_start, mean_done, out_free, load_out;
    rgb_sum_t           rd_sums, sum_next;
    logic [PIX_W-1:0]   mean_red, mean_green, mean_blue;
    logic               mean_done_r, mean_done_g, mean_done_b;

    assign accept      = s_valid && s_ready;
    assign frame_start = (col_reg == '0) && (row_reg == '0);
    assign fw_cap      = (src_w_reg > W_CAP) ? W_CAP : src_w_reg;
    assign fh_cap      = (src_h_reg > H_CAP) ? H_CAP : src_h_reg;

    always_comb begin
        case (state_reg)
            S_HF: begin
                sz_dividend = fw_reg;
                sz_divisor  = FACT_W'(max_ow_reg) + FACT_W'(1);
            end
            S_VF: begin
                sz_dividend = fh_reg;
                sz_divisor  = FACT_W'(max_oh_reg) + FACT_W'(1);
            end
            S_OW: begin
                sz_dividend = fw_reg;
                sz_divisor  = hf_reg;
            end
            S_OH: begin
                sz_dividend = fh_reg;
                sz_divisor  = vf_reg;
            end
            default: begin
                sz_dividend = fw_reg;
                sz_divisor  = hf_reg;
            end
        endcase
    end

    assign sz_start_next = ((state_reg == S_IDLE) && accept && frame_start &&
                            (fw_cap != '0) && (fh_cap != '0)) ||
                           (sz_done && ((state_reg == S_HF) || (state_reg == S_VF) ||
                                        (state_reg == S_OW)));

    rbd_div #(.DW(CFG_W), .VW(FACT_W), .QW(CFG_W)) u_size_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sz_start_reg),
        .dividend (sz_dividend),
        .divisor  (sz_divisor),
        .done     (sz_done),
        .quotient (sz_q)
    );

    assign sz_size = (sz_q == '0) ? CFG_W'(1) : sz_q;
    assign bw      = (hf_reg < FACT_W'(fw_reg)) ? hf_reg[CFG_W-1:0] : fw_reg;
    assign bh      = (vf_reg < FACT_W'(fh_reg)) ? vf_reg[CFG_W-1:0] : fh_reg;

    assign inbox    = (ox_reg < ow_reg) && (oy_reg < oh_reg);
    assign first    = (cx_reg == '0) && (cy_reg == '0);
    assign col_end  = (FACT_W'(col_reg) + FACT_W'(1)) == FACT_W'(fw_reg);
    assign row_end  = (FACT_W'(row_reg) + FACT_W'(1)) == FACT_W'(fh_reg);
    assign cx_end   = (FACT_W'(cx_reg) + FACT_W'(1)) == hf_reg;
    assign cy_end   = (FACT_W'(cy_reg) + FACT_W'(1)) == vf_reg;
    assign emit_x   = cx_end || col_end;
    assign emit_y   = cy_end || row_end;
    assign last_now = ((FACT_W'(ox_reg) + FACT_W'(1)) == FACT_W'(ow_reg)) &&
                      ((FACT_W'(oy_reg) + FACT_W'(1)) == FACT_W'(oh_reg));

    always_comb begin
        if (first) begin
            sum_next.red   = SUM_W'(pix_red_reg);
            sum_next.green = SUM_W'(pix_green_reg);
            sum_next.blue  = SUM_W'(pix_blue_reg);
        end else begin
            sum_next.red   = rd_sums.red + SUM_W'(pix_red_reg);
            sum_next.green = rd_sums.green + SUM_W'(pix_green_reg);
            sum_next.blue  = rd_sums.blue + SUM_W'(pix_blue_reg);
        end
    end

    assign wr_en      = (state_reg == S_MOD) && inbox;
    assign mean_start = wr_en && emit_x && emit_y;
    assign mean_done  = mean_done_r && mean_done_g && mean_done_b;
    assign out_free   = !m_valid_reg || m_ready;
    assign load_out   = (state_reg == S_OUT) && out_free;

    rbd_sum_mem #(.DEPTH(MAX_WIDTH), .AW(AW)) u_sum_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(ox_reg)),
        .wr_data (sum_next),
        .rd_addr (AW'(ox_reg)),
        .rd_data (rd_sums)
    );

    rbd_div #(.DW(SUM_W), .VW(CNT_W), .QW(PIX_W)) u_red_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mean_start),
        .dividend (sum_next.red),
        .divisor  (cnt_reg),
        .done     (mean_done_r),
        .quotient (mean_red)
    );

    rbd_div #(.DW(SUM_W), .VW(CNT_W), .QW(PIX_W)) u_green_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mean_start),
        .dividend (sum_next.green),
        .divisor  (cnt_reg),
        .done     (mean_done_g),
        .quotient (mean_green)
    );

    rbd_div #(.DW(SUM_W), .VW(CNT_W), .QW(PIX_W)) u_blue_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mean_start),
        .dividend (sum_next.blue),
        .divisor  (cnt_reg),
        .done     (mean_done_b),
        .quotient (mean_blue)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            src_w_reg    <= '0;
            src_h_reg    <= '0;
            max_ow_reg   <= MAX_OUT_W_RESET;
            max_oh_reg   <= MAX_OUT_H_RESET;
            fw_reg       <= '0;
            fh_reg       <= '0;
            hf_reg       <= FACT_W'(1);
            vf_reg       <= FACT_W'(1);
            col_reg      <= '0;
            row_reg      <= '0;
            cx_reg       <= '0;
            cy_reg       <= '0;
            ox_reg       <= '0;
            oy_reg       <= '0;
            sz_start_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            sz_start_reg <= sz_start_next;

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SRC_WIDTH:  src_w_reg  <= cfg_data;
                    REG_SRC_HEIGHT: src_h_reg  <= cfg_data;
                    REG_MAX_OUT_W:  max_ow_reg <= cfg_data;
                    REG_MAX_OUT_H:  max_oh_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (load_out) begin
                m_valid_reg   <= 1'b1;
                red_out_reg   <= mean_red;
                green_out_reg <= mean_green;
                blue_out_reg  <= mean_blue;
                last_out_reg  <= last_pend_reg;
                ow_out_reg    <= ow_reg;
                oh_out_reg    <= oh_reg;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        pix_red_reg   <= s_red_in;
                        pix_green_reg <= s_green_in;
                        pix_blue_reg  <= s_blue_in;
                        if (frame_start) begin
                            fw_reg <= fw_cap;
                            fh_reg <= fh_cap;
                            if (fw_cap != '0 && fh_cap != '0) begin
                                state_reg <= S_HF;
                            end
                        end else begin
                            state_reg <= S_MOD;
                        end
                    end
                end
                S_HF: begin
                    if (sz_done) begin
                        hf_reg    <= FACT_W'(sz_q) + FACT_W'(1);
                        state_reg <= S_VF;
                    end
                end
                S_VF: begin
                    if (sz_done) begin
                        vf_reg    <= FACT_W'(sz_q) + FACT_W'(1);
                        state_reg <= S_OW;
                    end
                end
                S_OW: begin
                    if (sz_done) begin
                        ow_reg    <= sz_size;
                        state_reg <= S_OH;
                    end
                end
                S_OH: begin
                    if (sz_done) begin
                        oh_reg    <= sz_size;
                        state_reg <= S_CNT;
                    end
                end
                S_CNT: begin
                    cnt_reg   <= CNT_W'(bw) * CNT_W'(bh);
                    state_reg <= S_MOD;
                end
                S_MOD: begin
                    last_pend_reg <= last_now;
                    if (col_end) begin
                        col_reg <= '0;
                        cx_reg  <= '0;
                        ox_reg  <= '0;
                        if (row_end) begin
                            row_reg <= '0;
                            cy_reg  <= '0;
                            oy_reg  <= '0;
                        end else begin
                            row_reg <= row_reg + CFG_W'(1);
                            if (cy_end) begin
                                cy_reg <= '0;
                                oy_reg <= oy_reg + CFG_W'(1);
                            end else begin
                                cy_reg <= cy_reg + CFG_W'(1);
                            end
                        end
                    end else begin
                        col_reg <= col_reg + CFG_W'(1);
                        if (cx_end) begin
                            cx_reg <= '0;
                            ox_reg <= ox_reg + CFG_W'(1);
                        end else begin
                            cx_reg <= cx_reg + CFG_W'(1);
                        end
                    end
                    state_reg <= mean_start ? S_DIV : S_IDLE;
                end
                S_DIV: begin
                    if (mean_done) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_red_out       = red_out_reg;
    assign m_green_out     = green_out_reg;
    assign m_blue_out      = blue_out_reg;
    assign m_alpha_out     = ALPHA_OPAQUE;
    assign m_last_of_frame = last_out_reg;
    assign m_output_width  = ow_out_reg;
    assign m_output_height = oh_out_reg;

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MOD) |-> (col_reg < fw_reg) && (FACT_W'(cx_reg) < hf_reg))
        else $error("source position outside frame or box");

    a_cnt_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        mean_start |-> (cnt_reg != '0))
        else $error("mean started with zero box count");

    a_addr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (32'(ox_reg) < MAX_WIDTH))
        else $error("sum memory address out of range");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) && m_valid_reg && !m_ready |=> (state_reg == S_OUT))
        else $error("result left before output register was free");

endmodule

@@ tb/tb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGBA box downscaler checker
// Watches the register port and both streams, predicts every output pixel
// from the accepted source pixels and compares each result transfer field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_checker
    import rbd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [PIX_W-1:0]     s_red_in,
    input  logic [PIX_W-1:0]     s_green_in,
    input  logic [PIX_W-1:0]     s_blue_in,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [PIX_W-1:0]     m_red_out,
    input  logic [PIX_W-1:0]     m_green_out,
    input  logic [PIX_W-1:0]     m_blue_out,
    input  logic [PIX_W-1:0]     m_alpha_out,
    input  logic                 m_last_of_frame,
    input  logic [CFG_W-1:0]     m_output_width,
    input  logic [CFG_W-1:0]     m_output_height,
    output int                   fail_count,
    output int                   pending_count
);

    localparam int FRAME_MAX = 1024;

    typedef struct {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
        logic             last;
        logic [CFG_W-1:0] out_w;
        logic [CFG_W-1:0] out_h;
    } out_pixel_t;

    out_pixel_t       expected_pixels[$];
    logic [CFG_W-1:0] src_w_reg, src_h_reg, max_w_reg, max_h_reg;
    logic [CFG_W-1:0] frame_w, frame_h, col, row;
    logic [FACT_W-1:0] h_fact, v_fact;
    logic [SUM_W-1:0] red_acc[FRAME_MAX];
    logic [SUM_W-1:0] green_acc[FRAME_MAX];
    logic [SUM_W-1:0] blue_acc[FRAME_MAX];
    int               errors = 0;

    assign fail_count = errors;

    task automatic absorb_pixel(input logic [PIX_W-1:0] r, g, b);
        int ow, oh, ox, oy, bx_end, by_end, bw, bh, cnt;
        out_pixel_t px;
        if (col == 0 && row == 0) begin
            frame_w = (src_w_reg > FRAME_MAX) ? CFG_W'(FRAME_MAX) : src_w_reg;
            frame_h = (src_h_reg > FRAME_MAX) ? CFG_W'(FRAME_MAX) : src_h_reg;
            if (frame_w == 0 || frame_h == 0)
                return;
            h_fact = frame_w / (max_w_reg + 1) + 1;
            v_fact = frame_h / (max_h_reg + 1) + 1;
        end
        ow = frame_w / h_fact;
        oh = frame_h / v_fact;
        if (ow == 0) ow = 1;
        if (oh == 0) oh = 1;
        ox = col / h_fact;
        oy = row / v_fact;
        if (ox < ow && oy < oh) begin
            if (col % h_fact == 0 && row % v_fact == 0) begin
                red_acc[ox]   = r;
                green_acc[ox] = g;
                blue_acc[ox]  = b;
            end else begin
                red_acc[ox]   += r;
                green_acc[ox] += g;
                blue_acc[ox]  += b;
            end
            bx_end = ox * h_fact + h_fact;
            by_end = oy * v_fact + v_fact;
            if (bx_end > frame_w) bx_end = frame_w;
            if (by_end > frame_h) by_end = frame_h;
            if (col + 1 == bx_end && row + 1 == by_end) begin
                bw  = (h_fact < frame_w) ? h_fact : frame_w;
                bh  = (v_fact < frame_h) ? v_fact : frame_h;
                cnt = bw * bh;
                px.red   = PIX_W'(red_acc[ox] / cnt);
                px.green = PIX_W'(green_acc[ox] / cnt);
                px.blue  = PIX_W'(blue_acc[ox] / cnt);
                px.alpha = ALPHA_OPAQUE;
                px.last  = (ox + 1 == ow && oy + 1 == oh);
                px.out_w = CFG_W'(ow);
                px.out_h = CFG_W'(oh);
                expected_pixels = {expected_pixels, px};
            end
        end
        col = col + 1;
        if (col >= frame_w) begin
            col = 0;
            row = row + 1;
            if (row >= frame_h)
                row = 0;
        end
    endtask

    always @(posedge aclk) begin
        out_pixel_t want;
        if (!aresetn) begin
            src_w_reg = '0;
            src_h_reg = '0;
            max_w_reg = MAX_OUT_W_RESET;
            max_h_reg = MAX_OUT_H_RESET;
            col       = '0;
            row       = '0;
            h_fact    = 1;
            v_fact    = 1;
            expected_pixels.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SRC_WIDTH:  src_w_reg = cfg_data;
                    REG_SRC_HEIGHT: src_h_reg = cfg_data;
                    REG_MAX_OUT_W:  max_w_reg = cfg_data;
                    REG_MAX_OUT_H:  max_h_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                absorb_pixel(s_red_in, s_green_in, s_blue_in);
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected output pixel r=%0d g=%0d b=%0d",
                                 m_red_out, m_green_out, m_blue_out);
                end else begin
                    want = expected_pixels.pop_front();
                    if (want.red !== m_red_out || want.green !== m_green_out ||
                        want.blue !== m_blue_out || want.alpha !== m_alpha_out ||
                        want.last !== m_last_of_frame || want.out_w !== m_output_width ||
                        want.out_h !== m_output_height) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch exp r%0d g%0d b%0d a%0d l%0d %0dx%0d",
                                     want.red, want.green, want.blue, want.alpha,
                                     want.last, want.out_w, want.out_h);
                            $display("         got r%0d g%0d b%0d a%0d l%0d %0dx%0d",
                                     m_red_out, m_green_out, m_blue_out, m_alpha_out,
                                     m_last_of_frame, m_output_width, m_output_height);
                        end
                    end
                end
            end
        end
        pending_count <= expected_pixels.size();
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGBA box downscaler testbench top
// Drives register settings and source frames of directed and random size
// with random content and random stalls on both streams; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import rbd_pkg::*;

    localparam int IDLE_LIMIT   = 20000;
    localparam int SETTLE_TICKS = 80;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SRC_WIDTH;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [PIX_W-1:0]     s_red_in = '0, s_green_in = '0, s_blue_in = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [PIX_W-1:0]     m_red_out, m_green_out, m_blue_out, m_alpha_out;
    logic                 m_last_of_frame;
    logic [CFG_W-1:0]     m_output_width, m_output_height;
    int                   fail_count, pending_count;
    int                   idle_ticks = 0;
    int                   stall_left = 0;
    int                   pixels_sent = 0;
    bit                   quiet = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    rgba_box_downscaler_core u_dut (.*);

    tb_checker u_checker (.*);

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PIX_W-1:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            stall_left <= pick_gap();
            m_ready    <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_ticks <= 0;
        else
            idle_ticks <= idle_ticks + 1;
        if (idle_ticks >= IDLE_LIMIT) begin
            $display("rgba_box_downscaler_core verification failed");
            $finish;
        end
    end

    task automatic send_pixel();
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_red_in   <= pick_byte();
        s_green_in <= pick_byte();
        s_blue_in  <= pick_byte();
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge aclk);
    endtask

    task automatic run_frames(input int sw, sh, max_w, max_h, frames);
        int total, hold_at;
        drain();
        repeat (SETTLE_TICKS) @(posedge aclk);
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_MAX_OUT_W, max_w);
        write_reg(REG_MAX_OUT_H, max_h);
        cfg_wr_en <= 1'b0;
        quiet   = ($urandom_range(0, 5) == 0);
        total   = (sw == 0 || sh == 0) ? 3 : sw * sh * frames;
        hold_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, total - 1) : -1;
        for (int i = 0; i < total; i++) begin
            if (i == hold_at) drain();
            send_pixel();
        end
        if (sw != 0 && sh != 0) pixels_sent += total;
    endtask

    initial begin
        int sw, sh;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero source size straight out of reset: pixels are dropped
        for (int i = 0; i < 3; i++) send_pixel();
        run_frames(3, 0, 160, 120, 1);
        run_frames(4, 4, 2, 2, 1);
        run_frames(3, 3, 0, 0, 2);
        run_frames(5, 3, 2, 1, 1);
        run_frames(7, 5, 3, 2, 1);
        run_frames(256, 1, 1024, 1024, 1);
        run_frames(256, 1, 1, 0, 1);
        run_frames(1, 256, 1024, 1, 1);

        while (pixels_sent < 1000) begin
            sw = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 24);
            sh = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
            run_frames(sw, sh, $urandom_range(0, sw + 2), $urandom_range(0, sh + 2),
                       $urandom_range(1, 3));
        end

        drain();
        repeat (SETTLE_TICKS) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("rgba_box_downscaler_core verification clean");
        else
            $display("rgba_box_downscaler_core verification failed");
        $finish;
    end

endmodule

@@ rgba_box_downscaler_core.f @@
sv/rbd_pkg.sv
sv/rbd_div.sv
sv/rbd_sum_mem.sv
sv/rgba_box_downscaler_core.sv
tb/tb_checker.sv
tb/tb_top.sv
